// ===== hdl/pulse_speed_odometer_defines.svh =====
// Assertion macros for the pulse speed odometer.
// Included by the top level; it depends on nothing else.
`ifndef PULSE_SPEED_ODOMETER_DEFINES_SVH
`define PULSE_SPEED_ODOMETER_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define PSO_ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("pulse_speed_odometer: invariant violated");

// A condition that must hold in the cycle after a trigger.
`define PSO_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("pulse_speed_odometer: sequence violated");

`endif

// ===== hdl/pso_pkg.sv =====
// Shared constants for the pulse speed odometer.
// No dependencies; used by the top level.
package pso_pkg;

    localparam int TS_W       = 21;
    localparam int SPD_W      = 11;
    localparam int ODO_W      = 48;
    localparam int CNT_W      = 32;
    localparam int PPK_W      = 16;
    localparam int DEN_W      = 21;
    localparam int HOUR_W     = 32;
    localparam int RAW_NUM_W  = 36;
    localparam int KM_BITS    = 10;

    localparam logic [HOUR_W-1:0] US_PER_HOUR    = 32'd3600000000;
    localparam logic [PPK_W-1:0]  PPK_RESET      = 16'd1000;
    localparam logic [PPK_W-1:0]  METERS_PER_KM  = 16'd1000;
    localparam logic [SPD_W-1:0]  SPEED_LIMIT    = 11'd1500;
    localparam logic [SPD_W-1:0]  FOLLOW_BAND    = 11'd50;
    localparam logic [SPD_W-1:0]  SLEW_STEP      = 11'd20;

endpackage

// ===== hdl/pso_div.sv =====
// Bit-serial restoring divider, one quotient bit per clock.
// The numerator arrives left-aligned; no package dependencies.
module pso_div #(
    parameter int NUM_W = 36,
    parameter int DEN_W = 21
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [$clog2(NUM_W+1)-1:0] len,
    input  logic [NUM_W-1:0]           num,
    input  logic [DEN_W-1:0]           den,
    output logic                       done,
    output logic [NUM_W-1:0]           quot
);
    localparam int CW = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [CW-1:0]    cnt_reg;
    logic             done_reg;

    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             fits;

    always_comb begin
        shifted = {rem_reg, quo_reg[NUM_W-1]};
        diff    = shifted - {1'b0, den_reg};
        fits    = shifted >= {1'b0, den_reg};
    end

    // The partial remainder stays below the divisor, so it fits DEN_W bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
            rem_reg  <= '0;
            den_reg  <= '0;
            quo_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg <= '0;
                den_reg <= den;
                quo_reg <= num;
                cnt_reg <= len;
            end else if (cnt_reg != '0) begin
                rem_reg  <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
                quo_reg  <= {quo_reg[NUM_W-2:0], fits};
                cnt_reg  <= cnt_reg - CW'(1);
                done_reg <= (cnt_reg == CW'(1));
            end
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

// ===== hdl/pulse_speed_odometer.sv =====
// Each request runs the odometer division, then the hour and raw-speed divisions, then the slew step;
// a zero ratio or a zero average skips divisions.
// All three divisions share one divider.
// A new request is taken once the previous result sits in the output register.
// Reset (synchronous, aresetn low): all state cleared, pulses_per_km set to 1000.
`include "pulse_speed_odometer_defines.svh"

module pulse_speed_odometer #(
    parameter int TIMER_PERIOD_MS = 2048,
    parameter int ODO_FRAC_BITS   = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [pso_pkg::TS_W-1:0]     s_timestamp_us,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [pso_pkg::SPD_W-1:0]    m_speed_tenths_kmh,
    output logic                         m_over_limit,
    output logic [pso_pkg::TS_W-1:0]     m_average_interval_us,
    output logic [pso_pkg::ODO_W-1:0]    m_odometer_q16_m,
    output logic [pso_pkg::CNT_W-1:0]    m_pulse_count,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [pso_pkg::PPK_W-1:0]    cfg_pulses_per_km
);
    localparam int PERIOD_US = TIMER_PERIOD_MS * 1000;
    localparam int IW        = $clog2(PERIOD_US + 2**pso_pkg::TS_W) + 1;
    localparam int ODO_NUM_W = ODO_FRAC_BITS + pso_pkg::KM_BITS;
    localparam int NUM_W     = (ODO_NUM_W > pso_pkg::RAW_NUM_W) ? ODO_NUM_W
                                                                : pso_pkg::RAW_NUM_W;
    localparam int CW        = $clog2(NUM_W + 1);
    localparam logic [NUM_W-1:0] ODO_NUM  =
        NUM_W'(pso_pkg::METERS_PER_KM) << (NUM_W - pso_pkg::KM_BITS);
    localparam logic [NUM_W-1:0] HOUR_NUM =
        NUM_W'(pso_pkg::US_PER_HOUR) << (NUM_W - pso_pkg::HOUR_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ODO_WAIT,
        ST_HOUR,
        ST_HOUR_WAIT,
        ST_RAW_WAIT,
        ST_SLEW
    } state_t;

    state_t                      state_reg;
    logic [pso_pkg::PPK_W-1:0]   ppk_reg;
    logic [pso_pkg::TS_W-1:0]    last_reg;
    logic [pso_pkg::TS_W-1:0]    avg_reg;
    logic [pso_pkg::SPD_W-1:0]   filt_reg;
    logic [pso_pkg::ODO_W-1:0]   odo_reg;
    logic [pso_pkg::CNT_W-1:0]   cnt_reg;
    logic [pso_pkg::SPD_W-1:0]   raw_reg;
    logic                        raw_over_reg;
    logic                        m_valid_reg;
    logic [pso_pkg::SPD_W-1:0]   m_speed_reg;
    logic                        m_over_reg;
    logic [pso_pkg::TS_W-1:0]    m_avg_reg;
    logic [pso_pkg::ODO_W-1:0]   m_odo_reg;
    logic [pso_pkg::CNT_W-1:0]   m_cnt_reg;

    logic                        accept;
    logic [IW-1:0]               interval;
    logic [IW:0]                 avg_sum;
    logic [pso_pkg::TS_W-1:0]    avg_next;
    logic [pso_pkg::CNT_W-1:0]   cnt_next;
    logic [pso_pkg::RAW_NUM_W-1:0] per_hour_x10;
    logic [pso_pkg::SPD_W-1:0]   spd_next;
    logic [pso_pkg::SPD_W-1:0]   gap;
    logic                        div_waiting;

    logic                        div_start;
    logic [CW-1:0]               div_len;
    logic [NUM_W-1:0]            div_num;
    logic [pso_pkg::DEN_W-1:0]   div_den;
    logic                        div_done;
    logic [NUM_W-1:0]            div_quot;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign cnt_next  = cnt_reg + pso_pkg::CNT_W'(1);
    assign div_waiting = (state_reg == ST_ODO_WAIT) || (state_reg == ST_HOUR_WAIT) ||
                         (state_reg == ST_RAW_WAIT);

    always_comb begin
        if (s_timestamp_us >= last_reg) begin
            interval = IW'(s_timestamp_us) - IW'(last_reg);
        end else begin
            interval = IW'(PERIOD_US) + IW'(s_timestamp_us) - IW'(last_reg);
        end
        avg_sum  = (IW+1)'(avg_reg) + (IW+1)'(interval);
        avg_next = avg_sum[pso_pkg::TS_W:1];
        per_hour_x10 = (pso_pkg::RAW_NUM_W'(div_quot[pso_pkg::HOUR_W-1:0]) << 3)
                     + (pso_pkg::RAW_NUM_W'(div_quot[pso_pkg::HOUR_W-1:0]) << 1);
    end

    // Speed filter: zero when over the limit, follow the raw speed inside the band, otherwise slew toward it.
    always_comb begin
        gap = (filt_reg >= raw_reg) ? (filt_reg - raw_reg) : (raw_reg - filt_reg);
        if (raw_over_reg) begin
            spd_next = '0;
        end else if (gap < pso_pkg::FOLLOW_BAND) begin
            spd_next = raw_reg;
        end else if (filt_reg >= raw_reg) begin
            spd_next = filt_reg - pso_pkg::SLEW_STEP;
        end else begin
            spd_next = filt_reg + pso_pkg::SLEW_STEP;
        end
    end

    always_comb begin
        div_start = 1'b0;
        div_len   = CW'(ODO_NUM_W);
        div_num   = ODO_NUM;
        div_den   = pso_pkg::DEN_W'(ppk_reg);
        case (state_reg)
            ST_IDLE: begin
                div_start = accept && (ppk_reg != '0);
            end
            ST_HOUR: begin
                div_start = (ppk_reg != '0) && (avg_reg != '0);
                div_len   = CW'(pso_pkg::HOUR_W);
                div_num   = HOUR_NUM;
                div_den   = avg_reg;
            end
            ST_HOUR_WAIT: begin
                div_start = div_done;
                div_len   = CW'(pso_pkg::RAW_NUM_W);
                div_num   = NUM_W'(per_hour_x10) << (NUM_W - pso_pkg::RAW_NUM_W);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    pso_div #(
        .NUM_W (NUM_W),
        .DEN_W (pso_pkg::DEN_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .len     (div_len),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ppk_reg      <= pso_pkg::PPK_RESET;
            last_reg     <= '0;
            avg_reg      <= '0;
            filt_reg     <= '0;
            odo_reg      <= '0;
            cnt_reg      <= '0;
            raw_reg      <= '0;
            raw_over_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            m_speed_reg  <= '0;
            m_over_reg   <= 1'b0;
            m_avg_reg    <= '0;
            m_odo_reg    <= '0;
            m_cnt_reg    <= '0;
        end else begin
            if (cfg_valid) begin
                ppk_reg <= cfg_pulses_per_km;
            end
            // In the slew state the output register is refilled below instead.
            if (m_valid_reg && m_ready && (state_reg != ST_SLEW)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        last_reg  <= s_timestamp_us;
                        avg_reg   <= avg_next;
                        cnt_reg   <= cnt_next;
                        state_reg <= (ppk_reg != '0) ? ST_ODO_WAIT : ST_HOUR;
                    end
                end
                ST_ODO_WAIT: begin
                    if (div_done) begin
                        odo_reg   <= odo_reg + pso_pkg::ODO_W'(div_quot[ODO_NUM_W-1:0]);
                        state_reg <= ST_HOUR;
                    end
                end
                ST_HOUR: begin
                    if ((ppk_reg != '0) && (avg_reg != '0)) begin
                        state_reg <= ST_HOUR_WAIT;
                    end else begin
                        raw_reg      <= '0;
                        raw_over_reg <= 1'b0;
                        state_reg    <= ST_SLEW;
                    end
                end
                ST_HOUR_WAIT: begin
                    if (div_done) begin
                        state_reg <= ST_RAW_WAIT;
                    end
                end
                ST_RAW_WAIT: begin
                    if (div_done) begin
                        raw_reg      <= div_quot[pso_pkg::SPD_W-1:0];
                        raw_over_reg <= (div_quot >= NUM_W'(pso_pkg::SPEED_LIMIT));
                        state_reg    <= ST_SLEW;
                    end
                end
                ST_SLEW: begin
                    if (!m_valid_reg || m_ready) begin
                        filt_reg    <= spd_next;
                        m_valid_reg <= 1'b1;
                        m_speed_reg <= spd_next;
                        m_over_reg  <= raw_over_reg;
                        m_avg_reg   <= avg_reg;
                        m_odo_reg   <= odo_reg;
                        m_cnt_reg   <= cnt_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid               = m_valid_reg;
    assign m_speed_tenths_kmh    = m_speed_reg;
    assign m_over_limit          = m_over_reg;
    assign m_average_interval_us = m_avg_reg;
    assign m_odometer_q16_m      = m_odo_reg;
    assign m_pulse_count         = m_cnt_reg;

    `PSO_ASSERT_ALWAYS(a_speed_range, aclk, aresetn, m_speed_reg < pso_pkg::SPEED_LIMIT)
    `PSO_ASSERT_ALWAYS(a_over_forces_zero, aclk, aresetn, !m_over_reg || (m_speed_reg == '0))
    `PSO_ASSERT_ALWAYS(a_done_when_waiting, aclk, aresetn, !div_done || div_waiting)
    `PSO_ASSERT_NEXT(a_count_step, aclk, aresetn, accept, cnt_reg == $past(cnt_next))

endmodule
